>>> rtl/key_matrix_pattern_debounce_top_defines.svh
// Assertion macros used by the debounce top to check the block.
`ifndef KEY_MATRIX_PATTERN_DEBOUNCE_TOP_DEFINES_SVH
`define KEY_MATRIX_PATTERN_DEBOUNCE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define KMPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmpd: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define KMPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmpd: next-cycle check failed");

`endif

>>> rtl/kmpd_pkg.sv
package kmpd_pkg;

	localparam int ROWS = 18;
	localparam int COLS = 8;
	localparam int KEYS = ROWS * COLS;

	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 3;
	localparam int MAP_W       = 8;
	localparam int COUNT_OUT_W = 8;
	localparam int HIST_W      = 8;
	localparam int LEN_W       = 3;

	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int CNT_W     = $clog2(KEYS + 1);

	localparam logic [LEN_W-1:0] LEN_RESET = 3'd4;
	localparam logic [LEN_W-1:0] LEN_MIN   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_MAX   = 3'd7;

	localparam logic [HIST_W-1:0] HIST_ALL_ZERO = 8'h00;
	localparam logic [HIST_W-1:0] HIST_ALL_ONE  = 8'hFF;
	localparam logic [HIST_W-1:0] PAT_FAST      = 8'h01;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_KEY     = 2'd0,
		KIND_BAD_COL = 2'd1,
		KIND_BAD_ROW = 2'd2
	} kmpd_kind_t;

	typedef struct packed {
		logic [ROW_FIELD_W-1:0] key_row;
		logic [COL_FIELD_W-1:0] key_col;
		logic                   sample_level;
	} kmpd_in_t;

	typedef struct packed {
		logic                   key_pressed;
		logic [MAP_W-1:0]       row_bits;
		logic [COUNT_OUT_W-1:0] pressed_count;
	} kmpd_out_t;

	// Classified word handed from the front to the back.
	typedef struct packed {
		kmpd_kind_t             kind;
		logic [ROW_IDX_W-1:0]   row;
		logic [COL_FIELD_W-1:0] col;
		logic [SLOT_W-1:0]      slot;
		logic                   level;
	} kmpd_item_t;

endpackage

>>> rtl/kmpd_front.sv
module kmpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kmpd_pkg::kmpd_in_t  in_data,
	output logic                push_valid,
	output kmpd_pkg::kmpd_item_t push_item,
	input  logic                push_ready
);
	import kmpd_pkg::*;

	logic       valid_s1;
	kmpd_item_t item_s1;
	kmpd_item_t item_d;
	logic       advance;

	// Classify the sample and form the history slot (column major).
	always_comb begin
		item_d       = '0;
		item_d.col   = in_data.key_col;
		item_d.level = in_data.sample_level;
		if (in_data.key_row >= ROWS) begin
			// keep the row index inside the matrix; the back stage reports no row
			item_d.kind = KIND_BAD_ROW;
		end else if (in_data.key_col >= COLS) begin
			item_d.kind = KIND_BAD_COL;
			item_d.row  = ROW_IDX_W'(in_data.key_row);
		end else begin
			item_d.kind = KIND_KEY;
			item_d.row  = ROW_IDX_W'(in_data.key_row);
			item_d.slot = SLOT_W'(in_data.key_col * ROWS + in_data.key_row);
		end
	end

	assign advance    = !valid_s1 || push_ready;
	assign in_stall   = !advance;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/kmpd_queue.sv
module kmpd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  kmpd_pkg::kmpd_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output kmpd_pkg::kmpd_item_t head_item
);
	import kmpd_pkg::*;

	kmpd_item_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/kmpd_back.sv
module kmpd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [kmpd_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                         head_valid,
	input  kmpd_pkg::kmpd_item_t         head_item,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output kmpd_pkg::kmpd_out_t          out_data
);
	import kmpd_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [HIST_W-1:0] hist_mem [KEYS];
	logic [KEYS-1:0]   hvalid_q;
	logic [COLS-1:0]   rows_q [ROWS];
	logic [CNT_W-1:0]  cnt_q;
	logic [HIST_W-1:0] hist_wr_q;

	logic              valid_s2;
	kmpd_item_t        item_s2;
	logic [HIST_W-1:0] rdata_s2;
	logic              fwd_s2;

	logic              out_valid_q;
	kmpd_out_t         out_data_q;

	logic              advance;
	logic              is_key;
	logic              commit;
	logic [LEN_W-1:0]  eff_len;
	logic [HIST_W-1:0] mask;
	logic [HIST_W-1:0] pat_safe;
	logic [HIST_W-1:0] hist_old;
	logic [HIST_W-1:0] hist_new;
	logic [HIST_W-1:0] masked;
	logic [COLS-1:0]   bit_vec;
	logic [COLS-1:0]   row_prev;
	logic [COLS-1:0]   after;
	logic              rise;
	logic              fall;
	logic [CNT_W-1:0]  cnt_next;
	kmpd_out_t         res;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && head_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_key = (item_s2.kind == KIND_KEY);
	assign commit = advance && valid_s2 && is_key;

	always_comb begin
		eff_len  = (len_q == '0) ? LEN_MIN : len_q;
		mask     = HIST_ALL_ONE >> (LEN_MAX - eff_len);
		pat_safe = mask >> 1;
		if (fwd_s2) begin
			hist_old = hist_wr_q;
		end else if (hvalid_q[item_s2.slot]) begin
			hist_old = rdata_s2;
		end else begin
			hist_old = HIST_ALL_ZERO;
		end
		hist_new = {hist_old[HIST_W-2:0], item_s2.level};
		masked   = hist_new & mask;
		bit_vec  = COLS'(1) << item_s2.col;
		row_prev = rows_q[item_s2.row];
		after    = row_prev;
		if (is_key && hist_new != HIST_ALL_ZERO && hist_new != HIST_ALL_ONE) begin
			if (masked == PAT_FAST || masked == pat_safe) begin
				after = row_prev | bit_vec;
			end else if (masked == (PAT_FAST ^ mask) || masked == (pat_safe ^ mask)) begin
				after = row_prev & ~bit_vec;
			end
		end
		rise = is_key && (|(after & bit_vec)) && !(|(row_prev & bit_vec));
		fall = is_key && !(|(after & bit_vec)) && (|(row_prev & bit_vec));
		cnt_next = cnt_q;
		if (rise) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (fall && cnt_q != '0) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
		res.key_pressed = is_key && (|(after & bit_vec));
		res.row_bits    = (item_s2.kind == KIND_BAD_ROW) ? '0 : MAP_W'(after);
		res.pressed_count = (cnt_next > 255) ? 8'hFF : COUNT_OUT_W'(cnt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_RESET;
			hvalid_q    <= '0;
			cnt_q       <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				rows_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (advance) begin
				valid_s2    <= head_valid;
				out_valid_q <= valid_s2;
			end
			if (commit) begin
				hvalid_q[item_s2.slot] <= 1'b1;
				rows_q[item_s2.row]    <= after;
				cnt_q                  <= cnt_next;
			end
		end
	end

	// History memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (commit) begin
			hist_mem[item_s2.slot] <= hist_new;
			hist_wr_q              <= hist_new;
		end
		if (pop) begin
			rdata_s2 <= hist_mem[head_item.slot];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2    <= head_item;
			fwd_s2     <= commit && head_item.kind == KIND_KEY
				&& head_item.slot == item_s2.slot;
			out_data_q <= res;
		end
	end

endmodule

>>> rtl/key_matrix_pattern_debounce_top.sv
// Key matrix debounce: one raw key sample in, one debounced word out.
// Input channel in_valid/in_stall/in_data carries a word of row, column and
// contact level. Output channel out_valid/out_stall/out_data returns the
// sampled key's debounced state, its row bitmap and the pressed-key count.
// A word is taken at a rising edge with valid high and stall low.
// cfg_we/cfg_wdata write the debounce length (0 acts as 1); write it only
// while no word is in flight.
// Path: a word passes the front register, the queue, the history read stage
// and the output register. Throughput: one word per cycle while out_stall is
// low, set by the history memory read-modify-write in the back stage; a
// same-key word right behind another takes forwarded data.
// Reset: clears the matrix, the pressed count and the per-key history valid
// bits (unwritten history reads as zero), and loads length 4. No clearing pass.
// Receiver stall: the output word and the back stage hold; the two-entry
// queue keeps filling, and in_stall rises once the front word cannot enter it.
`include "key_matrix_pattern_debounce_top_defines.svh"

module key_matrix_pattern_debounce_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [kmpd_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  kmpd_pkg::kmpd_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output kmpd_pkg::kmpd_out_t        out_data
);
	import kmpd_pkg::*;

	// front -> queue
	logic       f_valid;
	kmpd_item_t f_item;
	logic       q_full;
	// queue -> back
	logic       q_head_valid;
	kmpd_item_t q_head_item;
	logic       q_pop;

	// Classify the word and hold it until the queue has room.
	kmpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (!q_full)
	);

	// Decouple front and back so each can stall on its own.
	kmpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head_item)
	);

	// Advance history, matrix and count; drive the output register.
	kmpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// An accepted word always lands in the front register.
	`KMPD_ASSERT_NXT(a_front_loads, in_valid && !in_stall, f_valid)
	// The front never drives a word while the queue is full without stalling.
	`KMPD_ASSERT_IMP(a_hold_when_full, f_valid && q_full, in_stall)
	// A head word seen with an empty output must pass the read and output registers.
	`KMPD_ASSERT_IMP(a_drain, q_head_valid && !out_valid, ##2 out_valid)

endmodule

>>> sim/key_matrix_pattern_debounce_top_test.sv
module key_matrix_pattern_debounce_top_test;
	import kmpd_pkg::*;

	// Run limit in cycles, far above the slowest correct run:
	// ~1550 words, each with the longest send gap, the longest receive stall
	// and its pass through the pipeline, plus two long receiver hold-offs.
	localparam int CYCLE_LIMIT      = 400000;
	localparam int LONG_HOLD        = 300;
	localparam int RANDOM_PER_PHASE = 110;
	localparam int PHASES           = 8;
	localparam int MAX_PRINTS       = 50;
	localparam int ROW_FIELD_MAX    = (1 << ROW_FIELD_W) - 1;

	// A written length of zero acts as the shortest length.
	localparam logic [LEN_W-1:0] LEN_ZERO = 3'd0;

	// One row of the directed table: the word to send and, where typed, the
	// result it must give. Untyped rows are checked against the predictor.
	typedef struct packed {
		kmpd_in_t  word;
		logic      typed;
		kmpd_out_t result;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [LEN_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	kmpd_in_t            in_data;
	logic                out_valid;
	logic                out_stall;
	kmpd_out_t           out_data;

	// Predictor state: per-key sample history, debounced matrix, pressed count
	// and the debounce length in force.
	logic [HIST_W-1:0]   key_hist [ROWS][COLS];
	logic [MAP_W-1:0]    row_map [ROWS];
	int unsigned         pressed_keys;
	logic [LEN_W-1:0]    db_len;

	// Results still owed by the block, oldest first.
	kmpd_out_t           expected_words [$];

	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	bit                  tx_gaps_on;
	bit                  rx_gaps_on;
	bit                  hold_req;

	// Debounce length for each phase: zero (acts as one), both extremes, the
	// reset value and the values between.
	logic [LEN_W-1:0]    phase_len [PHASES] = '{
		LEN_ZERO, LEN_MAX, 3'd3, LEN_MIN, 3'd5, 3'd2, 3'd6, LEN_RESET
	};

	// Directed words, sent right after reset with length 4 (mask 0x1F).
	stim_row_t directed_rows [19] = '{
		// fast press on a clean history: first key down, count 1
		'{'{5'd0, 3'd0, 1'b1}, 1'b1, '{1'b1, 8'h01, 8'd1}},
		// fast press on the last row and last column
		'{'{5'd17, 3'd7, 1'b1}, 1'b1, '{1'b1, 8'h80, 8'd2}},
		// rows past the matrix: nothing moves, only the count comes back
		'{'{5'd18, 3'd0, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'd2}},
		'{'{5'd31, 3'd7, 1'b0}, 1'b1, '{1'b0, 8'h00, 8'd2}},
		// all-zero history leaves the key alone
		'{'{5'd3, 3'd2, 1'b0}, 1'b1, '{1'b0, 8'h00, 8'd2}},
		'{'{5'd17, 3'd6, 1'b0}, 1'b0, '0},
		// eight closed samples run the history into all ones
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		'{'{5'd2, 3'd1, 1'b1}, 1'b0, '0},
		// one open sample after that: fast release
		'{'{5'd2, 3'd1, 1'b0}, 1'b0, '0},
		// open samples on the first key walk it to a safe release
		'{'{5'd0, 3'd0, 1'b0}, 1'b0, '0},
		'{'{5'd0, 3'd0, 1'b0}, 1'b0, '0},
		'{'{5'd0, 3'd0, 1'b0}, 1'b0, '0},
		'{'{5'd0, 3'd0, 1'b0}, 1'b0, '0}
	};

	key_matrix_pattern_debounce_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit: end with a failure if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Print one line per mismatch (up to a cap) and count all of them.
	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s got %0h, want %0h",
				cycle_count, field, got, want);
		mismatch_count++;
	endtask

	// Clear the predictor to its state after reset.
	task automatic clear_debounce_state();
		for (int r = 0; r < ROWS; r++) begin
			row_map[r] = '0;
			for (int c = 0; c < COLS; c++)
				key_hist[r][c] = HIST_ALL_ZERO;
		end
		pressed_keys = 0;
		db_len = LEN_RESET;
	endtask

	// Shift one sample into the key's history, apply the press and release
	// patterns, and return the word the block must give for it.
	function automatic kmpd_out_t predict_debounce(input kmpd_in_t w);
		kmpd_out_t         r;
		int unsigned       eff_len;
		logic [HIST_W-1:0] span;
		logic [HIST_W-1:0] press_safe;
		logic [HIST_W-1:0] hist;
		logic [HIST_W-1:0] masked;
		logic [MAP_W-1:0]  col_bit;
		logic [MAP_W-1:0]  old_map;
		logic [MAP_W-1:0]  new_map;
		r = '0;
		if (w.key_row < ROWS && w.key_col < COLS) begin
			eff_len = (db_len == LEN_ZERO) ? 1 : db_len;
			span = HIST_ALL_ONE >> (int'(LEN_MAX) - eff_len);
			press_safe = span >> 1;
			hist = {key_hist[w.key_row][w.key_col][HIST_W-2:0], w.sample_level};
			key_hist[w.key_row][w.key_col] = hist;
			col_bit = MAP_W'(1) << w.key_col;
			old_map = row_map[w.key_row];
			new_map = old_map;
			// A steady history (all open or all closed) never changes the key.
			if (hist != HIST_ALL_ZERO && hist != HIST_ALL_ONE) begin
				masked = hist & span;
				if (masked == PAT_FAST || masked == press_safe)
					new_map = old_map | col_bit;
				else if (masked == (PAT_FAST ^ span) || masked == (press_safe ^ span))
					new_map = old_map & ~col_bit;
			end
			row_map[w.key_row] = new_map;
			if ((new_map & col_bit) != 0 && (old_map & col_bit) == 0)
				pressed_keys++;
			else if ((new_map & col_bit) == 0 && (old_map & col_bit) != 0 && pressed_keys > 0)
				pressed_keys--;
			r.key_pressed = |(new_map & col_bit);
			r.row_bits = new_map;
		end else if (w.key_row < ROWS) begin
			// column past the matrix: report the row, touch nothing
			r.row_bits = row_map[w.key_row];
		end
		r.pressed_count = (pressed_keys > 255) ? 8'd255 : pressed_keys[7:0];
		return r;
	endfunction

	// Offer one word after a random gap, hold it until taken, then record the
	// result it must give: the typed one where given, else the prediction.
	task automatic offer_word(input kmpd_in_t w, input logic typed,
			input kmpd_out_t typed_result);
		int        gap;
		kmpd_out_t predicted;
		gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		predicted = predict_debounce(w);
		expected_words.push_back(typed ? typed_result : predicted);
	endtask

	// Drop valid and wait until every owed word has come back.
	task automatic drain_words();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// Write the debounce length once the block is idle.
	task automatic write_length(input logic [LEN_W-1:0] len);
		drain_words();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		db_len = len;
	endtask

	// Walk every key with an opposite sample then the target level. At the
	// shortest length this presses (or releases) the whole matrix, which
	// drives the pressed count to its top and back to zero.
	task automatic sweep_matrix(input logic level);
		kmpd_in_t w;
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++) begin
				w.key_row = ROW_FIELD_W'(r);
				w.key_col = COL_FIELD_W'(c);
				w.sample_level = ~level;
				offer_word(w, 1'b0, '0);
				w.sample_level = level;
				offer_word(w, 1'b0, '0);
			end
	endtask

	// Random words: mostly bursts of one level on one key with the odd
	// bounce, so histories reach the press and release patterns; the rest is
	// single samples on random keys and words for rows past the matrix.
	task automatic random_phase(input int key_words);
		int       sent;
		int       run;
		int       kind;
		logic     burst_level;
		kmpd_in_t w;
		sent = 0;
		while (sent < key_words) begin
			kind = $urandom_range(0, 99);
			w.key_col = COL_FIELD_W'($urandom_range(0, COLS - 1));
			w.sample_level = 1'($urandom_range(0, 1));
			if (kind < 8) begin
				// ignored by the block, so not counted
				w.key_row = ROW_FIELD_W'($urandom_range(ROWS, ROW_FIELD_MAX));
				offer_word(w, 1'b0, '0);
			end else if (kind < 20) begin
				w.key_row = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
				offer_word(w, 1'b0, '0);
				sent++;
			end else begin
				w.key_row = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
				burst_level = 1'($urandom_range(0, 1));
				run = $urandom_range(1, 10);
				repeat (run) begin
					w.sample_level = ($urandom_range(0, 7) == 0) ? ~burst_level : burst_level;
					offer_word(w, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// Receiver: stall a random number of cycles per word, or for a long
	// stretch when asked, then take the next word and check it field by field.
	initial begin
		int        gap;
		kmpd_out_t want;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing owed", 32'(out_data), '0);
			end else begin
				want = expected_words.pop_front();
				if (out_data.key_pressed !== want.key_pressed)
					report_mismatch("key_pressed", 32'(out_data.key_pressed),
						32'(want.key_pressed));
				if (out_data.row_bits !== want.row_bits)
					report_mismatch("row_bits", 32'(out_data.row_bits),
						32'(want.row_bits));
				if (out_data.pressed_count !== want.pressed_count)
					report_mismatch("pressed_count", 32'(out_data.pressed_count),
						32'(want.pressed_count));
			end
		end
	end

	// Sender: reset, directed table, then one phase per debounce length.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= LEN_RESET;
		in_valid <= 1'b0;
		in_data <= '0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		hold_req = 1'b0;
		clear_debounce_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_word(directed_rows[i].word, directed_rows[i].typed,
				directed_rows[i].result);

		for (int p = 0; p < PHASES; p++) begin
			// each length change also makes the sender wait for every result
			write_length(phase_len[p]);
			// vary idling so some phases run back to back on one side
			tx_gaps_on = (p % 3 != 1);
			rx_gaps_on = (p % 4 != 2);
			// long receiver hold-offs fill the block until it stalls its input
			if (p == 4 || p == 6)
				hold_req = 1'b1;
			if (p == 0)
				sweep_matrix(1'b1);
			random_phase(p == 0 ? 100 : RANDOM_PER_PHASE);
			if (p == 0)
				sweep_matrix(1'b0);
		end

		drain_words();
		// give any stray word a chance to show up
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
